FILE: sv/histogram_equalizer_core_defines.svh
// Assertion macros shared by the histogram equalizer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define HEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/histeq_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the histogram equalizer core.
// No dependencies; imported by the top level and the testbench.
package histeq_pkg;

	localparam int HIST_BINS      = 256;
	localparam int BIN_IDX_W      = $clog2(HIST_BINS);
	localparam int COUNT_BITS_DEF = 24;
	localparam int PIX_W          = 8;
	localparam int MAP_W          = 8;
	localparam int DIM_W          = 13;
	localparam int AREA_W         = 2 * DIM_W;
	localparam int QUOT_W         = MAP_W + 1;
	localparam int REG_IDX_W      = 1;

	localparam logic [BIN_IDX_W-1:0] BIN_LAST = BIN_IDX_W'(HIST_BINS - 1);
	localparam logic [MAP_W-1:0]     MAP_MAX  = MAP_W'(255);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	// Item kinds
	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_MAP   = 1'b1;

endpackage

FILE: sv/histeq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module histeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/histeq_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on nothing but its parameters; used by the table build sequencer.
module histeq_divider #(
	parameter int NUM_W  = 40,
	parameter int DEN_W  = 26,
	parameter int QUOT_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  numerator,
	input  logic [DEN_W-1:0]  denominator,
	output logic              done,
	output logic [QUOT_W-1:0] quotient
);

	localparam int SH_W   = DEN_W + QUOT_W - 1;
	localparam int CMP_W  = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int STEP_W = $clog2(QUOT_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CMP_W-1:0]  rem_q;
	logic [CMP_W-1:0]  den_sh_q;
	logic [QUOT_W-1:0] quot_q;
	logic              fits;

	// Trial compare of the shared subtract unit
	assign fits = (rem_q >= den_sh_q);

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(QUOT_W);
		end else if (run_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Load operands, then subtract and shift one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= CMP_W'(numerator);
			den_sh_q <= CMP_W'(denominator) << (QUOT_W - 1);
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - den_sh_q;
			end
			den_sh_q <= den_sh_q >> 1;
			quot_q   <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: sv/histogram_equalizer_core.sv
`timescale 1ns / 1ps
// Top level of the histogram equalizer: control sequencer, histogram and map RAMs.
// Depends on histeq_pkg, histeq_ram, histeq_divider and the assertion macro header.
//
//  channel   handshake            payload
//  input     start / busy         kind, pixel_value, last_pixel
//  result    done (1-cycle pulse) mapped_value
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A count item reads its bin and writes it back in ST_CNT_UPD; a map item raises done in ST_MAP_OUT.
// A count item with last_pixel set then builds the table: ST_BLD_AREA once, then
// ST_BLD_RD, ACC, SCALE, DIV and WR per bin, bounded by the nine-step shared divider.
// Reset clears the histogram through per-bin valid bits; no clearing pass.
// busy stays high for the whole item; results cannot be stalled.
`include "histogram_equalizer_core_defines.svh"

module histogram_equalizer_core #(
	parameter int COUNT_BITS = histeq_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [histeq_pkg::PIX_W-1:0]     pixel_value,
	input  logic                             last_pixel,
	output logic                             done,
	output logic [histeq_pkg::MAP_W-1:0]     mapped_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [histeq_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [histeq_pkg::DIM_W-1:0]     cfg_data
);

	import histeq_pkg::*;

	localparam int RUN_W = COUNT_BITS + BIN_IDX_W;
	localparam int NUM_W = RUN_W + MAP_W;

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_CNT_UPD   = 9'b000000010,
		ST_MAP_OUT   = 9'b000000100,
		ST_BLD_AREA  = 9'b000001000,
		ST_BLD_RD    = 9'b000010000,
		ST_BLD_ACC   = 9'b000100000,
		ST_BLD_SCALE = 9'b001000000,
		ST_BLD_DIV   = 9'b010000000,
		ST_BLD_WR    = 9'b100000000
	} state_t;

	state_t                 state_q, state_d;
	logic [DIM_W-1:0]       width_q, height_q;
	logic [AREA_W-1:0]      area_q;
	logic [RUN_W-1:0]       running_q;
	logic [BIN_IDX_W-1:0]   bin_q;
	logic [PIX_W-1:0]       pix_q;
	logic                   last_q;
	logic                   built_q;
	logic [HIST_BINS-1:0]   bin_valid_q;
	logic                   accept;

	logic [COUNT_BITS-1:0]  hist_rdata, cur_count, new_count;
	logic [BIN_IDX_W-1:0]   hist_rd_addr;
	logic                   hist_wr_en;
	logic [MAP_W-1:0]       map_rdata, map_wdata;
	logic                   map_wr_en;
	logic [NUM_W-1:0]       numerator;
	logic                   div_start, div_done;
	logic [QUOT_W-1:0]      quotient;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_MAP) ? ST_MAP_OUT : ST_CNT_UPD;
				end
			end
			ST_CNT_UPD:   state_d = last_q ? ST_BLD_AREA : ST_IDLE;
			ST_MAP_OUT:   state_d = ST_IDLE;
			ST_BLD_AREA:  state_d = ST_BLD_RD;
			ST_BLD_RD:    state_d = ST_BLD_ACC;
			ST_BLD_ACC:   state_d = ST_BLD_SCALE;
			ST_BLD_SCALE: state_d = ST_BLD_DIV;
			ST_BLD_DIV:   state_d = div_done ? ST_BLD_WR : ST_BLD_DIV;
			ST_BLD_WR:    state_d = (bin_q == BIN_LAST) ? ST_IDLE : ST_BLD_RD;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_valid_q <= '0;
			built_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CNT_UPD) begin
				bin_valid_q[pix_q] <= 1'b1;
			end
			// Drop the whole histogram once the last bin is scaled
			if (state_q == ST_BLD_WR && bin_q == BIN_LAST) begin
				bin_valid_q <= '0;
				built_q     <= 1'b1;
			end
		end
	end

	// Item and build datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= pixel_value;
			last_q <= last_pixel;
		end
		case (state_q)
			ST_BLD_AREA: begin
				area_q    <= AREA_W'(width_q) * AREA_W'(height_q);
				running_q <= '0;
				bin_q     <= '0;
			end
			ST_BLD_ACC: begin
				running_q <= running_q + RUN_W'(cur_count);
			end
			ST_BLD_WR: begin
				bin_q <= bin_q + BIN_IDX_W'(1);
			end
			default: ;
		endcase
	end

	// Saturating bin increment; an unwritten bin reads as zero
	always_comb begin
		cur_count = (state_q == ST_CNT_UPD) ? (bin_valid_q[pix_q] ? hist_rdata : '0)
		                                    : (bin_valid_q[bin_q] ? hist_rdata : '0);
		new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);
	end

	assign hist_rd_addr = (state_q == ST_IDLE) ? pixel_value : bin_q;
	assign hist_wr_en   = (state_q == ST_CNT_UPD);

	histeq_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (HIST_BINS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (hist_wr_en),
		.wr_addr (pix_q),
		.wr_data (new_count),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rdata)
	);

	// Scale the running sum by 255 and divide by the frame area
	assign numerator = {running_q, MAP_W'(0)} - NUM_W'(running_q);
	assign div_start = (state_q == ST_BLD_SCALE);

	histeq_divider #(
		.NUM_W  (NUM_W),
		.DEN_W  (AREA_W),
		.QUOT_W (QUOT_W)
	) u_divider (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.numerator   (numerator),
		.denominator (area_q),
		.done        (div_done),
		.quotient    (quotient)
	);

	// Clamp quotients of 256 and above, including the zero-area case
	assign map_wdata = quotient[QUOT_W-1] ? MAP_MAX : quotient[MAP_W-1:0];
	assign map_wr_en = (state_q == ST_BLD_WR);

	histeq_ram #(
		.WIDTH (MAP_W),
		.DEPTH (HIST_BINS)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (bin_q),
		.wr_data (map_wdata),
		.rd_addr (pixel_value),
		.rd_data (map_rdata)
	);

	// Result transfer
	assign done         = (state_q == ST_MAP_OUT);
	assign mapped_value = built_q ? map_rdata : '0;

	`HEC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside an item")
	`HEC_ASSERT_NEXT(a_map_result, accept && kind == KIND_MAP, done,
		"map item gave no result")
	`HEC_ASSERT_NEXT(a_count_silent, accept && kind == KIND_COUNT, !done,
		"count item gave a result")
	`HEC_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
	`HEC_ASSERT_NOW(a_div_in_build, div_done, state_q == ST_BLD_DIV,
		"divider finished outside the table build")

endmodule

FILE: dv/tb_histogram_equalizer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for histogram_equalizer_core: count and map pixel streams.
// Depends on histeq_pkg and the core RTL; predicts the mapping table in place.
module tb_histogram_equalizer_core;
	import histeq_pkg::*;

	localparam int COUNT_W     = COUNT_BITS_DEF;
	localparam int BUILD_WAIT  = 3700;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 kind;
	logic [PIX_W-1:0]     pixel_value;
	logic                 last_pixel;
	logic                 done;
	logic [MAP_W-1:0]     mapped_value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	// Predicted block state
	logic [COUNT_W-1:0] hist_bins [HIST_BINS];
	logic [MAP_W-1:0]   eq_lut    [HIST_BINS];
	logic [DIM_W-1:0]   frame_width;
	logic [DIM_W-1:0]   frame_height;
	logic [MAP_W-1:0]   pending_maps [$];

	int error_count;
	int items_sent;
	int send_idle_pct;
	int cycle_count;

	histogram_equalizer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.pixel_value  (pixel_value),
		.last_pixel   (last_pixel),
		.done         (done),
		.mapped_value (mapped_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Turn the histogram into the mapping table, then clear it
	function automatic void rebuild_lut();
		longint unsigned area;
		longint unsigned running;
		longint unsigned scaled;
		area = 64'(frame_width) * 64'(frame_height);
		running = 0;
		for (int b = 0; b < HIST_BINS; b++) begin
			running += 64'(hist_bins[b]);
			if (area == 0)
				scaled = 255;
			else
				scaled = (running * 255) / area;
			if (scaled > 255)
				scaled = 255;
			eq_lut[b] = scaled[MAP_W-1:0];
			hist_bins[b] = '0;
		end
	endfunction

	// Apply one accepted item to the predicted state
	function automatic void predict_item(input logic k, input logic [PIX_W-1:0] p,
			input logic l);
		if (k == KIND_MAP) begin
			pending_maps.push_back(eq_lut[p]);
		end else begin
			// bins saturate at full scale
			if (hist_bins[p] != {COUNT_W{1'b1}})
				hist_bins[p] = hist_bins[p] + 1'b1;
			if (l)
				rebuild_lut();
		end
	endfunction

	// Present one item and hold it until the transfer; start stays high on return
	task automatic send_pixel(input logic k, input logic [PIX_W-1:0] p, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		pixel_value <= p;
		last_pixel  <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_item(k, p, l);
		items_sent++;
	endtask

	// Drop start and wait for all results and for busy to fall, then for the caller's extra wait
	task automatic drain_all(input int extra);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_maps.size() != 0 || busy);
		repeat (extra) @(posedge clk);
	endtask

	// Write both frame dimensions on the config channel; block must be idle
	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		drain_all(BUILD_WAIT);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_width = w;
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_height = h;
		cfg_valid <= 1'b0;
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		logic [MAP_W-1:0] want;
		if (arst_n && done) begin
			if (pending_maps.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", mapped_value));
			end else begin
				want = pending_maps.pop_front();
				if (mapped_value !== want)
					report_mismatch($sformatf("mapped_value %0d, want %0d",
						mapped_value, want));
			end
		end
	end

	// Table at reset is all zero; last_pixel on a map item is ignored
	task automatic test_map_before_build();
		send_pixel(KIND_MAP, 8'h00, 1'b0);
		send_pixel(KIND_MAP, 8'hFF, 1'b1);
		send_pixel(KIND_MAP, 8'hAA, 1'b0);
		send_pixel(KIND_MAP, 8'h55, 1'b1);
	endtask

	// Build with the reset frame size
	task automatic test_reset_frame();
		send_pixel(KIND_COUNT, 8'h00, 1'b0);
		send_pixel(KIND_COUNT, 8'hFF, 1'b0);
		send_pixel(KIND_COUNT, 8'h80, 1'b1);
		send_pixel(KIND_MAP, 8'h00, 1'b0);
		send_pixel(KIND_MAP, 8'hFF, 1'b0);
	endtask

	// More pixels than the frame area: scaled values clamp at full scale
	task automatic test_clamp();
		set_frame(DIM_W'(1), DIM_W'(1));
		send_pixel(KIND_COUNT, 8'h00, 1'b0);
		send_pixel(KIND_COUNT, 8'h00, 1'b0);
		send_pixel(KIND_COUNT, 8'hFF, 1'b1);
		send_pixel(KIND_MAP, 8'h00, 1'b0);
		send_pixel(KIND_MAP, 8'h7F, 1'b0);
		send_pixel(KIND_MAP, 8'hFF, 1'b0);
	endtask

	// Zero area saturates every entry; histogram still clears
	task automatic test_zero_area();
		set_frame(DIM_W'(0), DIM_W'(5));
		send_pixel(KIND_COUNT, 8'h10, 1'b1);
		send_pixel(KIND_MAP, 8'h00, 1'b0);
		set_frame(DIM_W'(8191), DIM_W'(0));
		send_pixel(KIND_COUNT, 8'h20, 1'b1);
		send_pixel(KIND_MAP, 8'hFF, 1'b0);
	endtask

	// Largest dimensions, in range and beyond
	task automatic test_big_frames();
		set_frame(DIM_W'(4096), DIM_W'(4096));
		send_pixel(KIND_COUNT, 8'h01, 1'b1);
		send_pixel(KIND_MAP, 8'h01, 1'b0);
		set_frame(DIM_W'(8191), DIM_W'(8191));
		send_pixel(KIND_COUNT, 8'hFE, 1'b1);
		send_pixel(KIND_MAP, 8'hFE, 1'b0);
	endtask

	// Random frames: counts closed by a last pixel, then maps; some noisy frames
	task automatic test_random_frames();
		int n_count;
		int n_map;
		int phase;
		int pick;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		phase = 0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			// change the frame size between some frames
			pick = $urandom_range(15);
			if (pick == 0)
				set_frame(DIM_W'($urandom_range(4096)), DIM_W'($urandom_range(8191)));
			else if (pick == 1)
				set_frame(DIM_W'(4096), DIM_W'(1));
			else if (pick == 2)
				set_frame(DIM_W'($urandom_range(1, 3)), DIM_W'(0));
			else if (pick < 10)
				set_frame(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
			// rotate through the idle phases
			case (phase % 4)
				0: send_idle_pct = 0;
				1: send_idle_pct = 63;
				2: send_idle_pct = 0;
				default: send_idle_pct = 22;
			endcase
			phase++;
			n_count = $urandom_range(1, 40);
			n_map = $urandom_range(1, 30);
			if ($urandom_range(9) == 0) begin
				// noise: interleaved kinds with random last bits
				repeat (n_count + n_map)
					send_pixel(1'($urandom_range(1)), PIX_W'($urandom),
						1'($urandom_range(3) == 0));
			end else begin
				repeat (n_count - 1)
					send_pixel(KIND_COUNT, PIX_W'($urandom), 1'b0);
				send_pixel(KIND_COUNT, PIX_W'($urandom), 1'b1);
				repeat (n_map)
					send_pixel(KIND_MAP, PIX_W'($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		kind        <= KIND_COUNT;
		pixel_value <= '0;
		last_pixel  <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_WIDTH;
		cfg_data    <= '0;
		error_count = 0;
		items_sent = 0;
		send_idle_pct = 0;
		frame_width = WIDTH_RESET;
		frame_height = HEIGHT_RESET;
		for (int b = 0; b < HIST_BINS; b++) begin
			hist_bins[b] = '0;
			eq_lut[b] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_map_before_build();
		test_reset_frame();
		test_clamp();
		test_zero_area();
		test_big_frames();
		test_random_frames();

		drain_all(20);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
